// File: hw/rtl/assert_macros.svh
// assertion helpers shared by the rtl
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, held off during reset
`define CHK_IMPLY(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("same-cycle implication failed");

// next-cycle implication, held off during reset
`define CHK_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("next-cycle implication failed");

`endif

// File: hw/rtl/ssdr_pkg.sv
package ssdr_pkg;

   localparam int TICK_BITS_DEF = 16;

   localparam int DUTY_W  = 10;
   localparam int VALUE_W = 16;
   localparam int LEN_W   = 16;
   localparam int OP_W    = 3;
   localparam int IDX_W   = 3;
   localparam int PROD_W  = DUTY_W + LEN_W;
   localparam int RSP_W   = 24;

   // quotient stays below 2**DUTY_W, so that many restoring steps suffice
   localparam int DIV_STEPS = DUTY_W;
   localparam int CNT_W     = $clog2(DIV_STEPS);

   typedef enum logic [OP_W-1:0] {
      OP_TICK   = 3'd0,
      OP_START  = 3'd1,
      OP_STOP   = 3'd2,
      OP_TARGET = 3'd3,
      OP_GATE   = 3'd4
   } op_type;

   typedef enum logic [IDX_W-1:0] {
      REG_SOFT_START_TICKS = 3'd0,
      REG_GATE_RAMP_TICKS  = 3'd1,
      REG_DUTY_FLOOR       = 3'd2,
      REG_DUTY_CEILING     = 3'd3,
      REG_GATE_START_DUTY  = 3'd4,
      REG_GATE_FLOOR       = 3'd5,
      REG_GATE_CEILING     = 3'd6,
      REG_GATE_DEFAULT     = 3'd7
   } reg_idx_type;

   typedef enum logic [5:0] {
      S_IDLE = 6'b000001,
      S_EVAL = 6'b000010,
      S_MUL  = 6'b000100,
      S_DIV  = 6'b001000,
      S_FIN  = 6'b010000,
      S_EMIT = 6'b100000
   } state_type;

   localparam logic [LEN_W-1:0]  RST_SOFT_START_TICKS = 16'd500;
   localparam logic [LEN_W-1:0]  RST_GATE_RAMP_TICKS  = 16'd100;
   localparam logic [DUTY_W-1:0] RST_DUTY_FLOOR       = 10'd0;
   localparam logic [DUTY_W-1:0] RST_DUTY_CEILING     = 10'd900;
   localparam logic [DUTY_W-1:0] RST_GATE_START_DUTY  = 10'd100;
   localparam logic [DUTY_W-1:0] RST_GATE_FLOOR       = 10'd50;
   localparam logic [DUTY_W-1:0] RST_GATE_CEILING     = 10'd500;
   localparam logic [DUTY_W-1:0] RST_GATE_DEFAULT     = 10'd450;

   // below the floor gives the floor, else above the ceiling gives the ceiling
   function automatic logic [DUTY_W-1:0] clamp_duty(input logic [VALUE_W-1:0] v,
                                                    input logic [DUTY_W-1:0] lo,
                                                    input logic [DUTY_W-1:0] hi);
      logic [DUTY_W-1:0] r;
      if (v < VALUE_W'(lo)) begin
         r = lo;
      end else if (v > VALUE_W'(hi)) begin
         r = hi;
      end else begin
         r = v[DUTY_W-1:0];
      end
      return r;
   endfunction

endpackage

// File: hw/rtl/soft_start_duty_ramp_top.sv
// soft-start duty ramp: drives a supply duty and a gate duty in 0.1 percent units
// req channel: one transfer per command, req_tuser = operation (tick, start, stop,
//   set target, set gate run duty), req_tdata = duty value for the two set commands
// rsp channel: exactly one transfer per command, showing duties and flags after it
// csr channel: register writes by index, always ready; user writes only while idle, unenforced
// sequence: start, stop, set and stopped-tick commands go from idle to the emit state,
//   a running tick first passes the eval state; a tick while ramping also runs the
//   shared multiply and 10-step restoring divide unit, through the mul, div and fin states,
//   once for a due supply ramp point and once for a due gate ramp point
// throughput: one command at a time; req_tready is low from transfer to result load
// the result sits in an output register, so a new command is taken while the
//   previous result still waits; if rsp_tready stays low the block holds the new
//   result until the register frees up and takes no further command
// reset (synchronous, active high): registers to their defaults, block stopped,
//   duties zero, gate run duty = gate default clamped to the gate limits
`include "assert_macros.svh"

module soft_start_duty_ramp_top
   import ssdr_pkg::*;
#(
   parameter int TICK_BITS = TICK_BITS_DEF
) (
   input  logic               clock,
   input  logic               reset,
   // command channel
   input  logic               req_tvalid,
   output logic               req_tready,
   input  logic [VALUE_W-1:0] req_tdata,   // [15:0] duty_value
   input  logic [OP_W-1:0]    req_tuser,   // [2:0] operation
   // result channel
   output logic               rsp_tvalid,
   input  logic               rsp_tready,
   output logic [RSP_W-1:0]   rsp_tdata,   // [9:0] supply_duty, [19:10] gate_level,
                                           // [20] output_enabled, [21] ramping_supply,
                                           // [22] ramping_gate, [23] zero
   // register write channel
   input  logic               csr_valid,
   output logic               csr_ready,
   input  logic [IDX_W-1:0]   csr_index,
   input  logic [VALUE_W-1:0] csr_data
);

   // tick count widened to at least the ramp length width for compares
   localparam int EW = (TICK_BITS > LEN_W) ? TICK_BITS : LEN_W;

   // configuration registers
   logic [LEN_W-1:0]  sst_ff, grt_ff;
   logic [DUTY_W-1:0] dfloor_ff, dceil_ff, gstart_ff, gfloor_ff, gceil_ff, gdef_ff;

   // ramp state
   logic                 active_ff, active_in;
   logic                 ramp_s_ff, ramp_s_in;
   logic                 ramp_g_ff, ramp_g_in;
   logic [TICK_BITS-1:0] ticks_ff, ticks_in;
   logic [DUTY_W-1:0]    origin_ff, origin_in;
   logic [DUTY_W-1:0]    target_ff, target_in;
   logic [DUTY_W-1:0]    present_ff, present_in;
   logic [DUTY_W-1:0]    grun_ff, grun_in;
   logic [DUTY_W-1:0]    drv_s_ff, drv_s_in;
   logic [DUTY_W-1:0]    drv_g_ff, drv_g_in;

   // sequencer and shared arithmetic unit
   state_type          state_ff, state_in;
   logic               sel_g_ff, sel_g_in;     // 0 supply ramp, 1 gate ramp
   logic               need_g_ff, need_g_in;   // gate ramp point still to compute
   logic               neg_ff, neg_in;
   logic [LEN_W-1:0]   rem_ff, rem_in;
   logic [DUTY_W-1:0]  quo_ff, quo_in;         // low dividend bits, then quotient
   logic [CNT_W-1:0]   cnt_ff, cnt_in;

   // output register
   logic               rsp_valid_ff, rsp_valid_in;
   logic [RSP_W-1:0]   rsp_data_ff, rsp_data_in;

   logic               req_xfer;
   logic               rsp_free;
   logic [EW-1:0]      tick_ext;
   logic               saturated;
   logic               s_end, g_end;
   logic [LEN_W-1:0]   elapsed;

   // operand select for the shared unit
   logic [DUTY_W-1:0]  op_from, op_to, op_lo, op_hi;
   logic [LEN_W-1:0]   op_len;
   logic [DUTY_W-1:0]  mag;
   logic [PROD_W-1:0]  product;
   logic [LEN_W:0]     rem_sh;
   logic               qbit;
   logic [DUTY_W-1:0]  ramp_raw, ramp_flr, ramp_val;
   op_type             req_op;

   assign req_tready = (state_ff == S_IDLE);
   assign req_xfer   = req_tvalid && req_tready;
   assign req_op     = op_type'(req_tuser);
   assign csr_ready  = 1'b1;
   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;
   assign rsp_free   = !rsp_valid_ff || rsp_tready;

   assign tick_ext  = EW'(ticks_ff);
   assign saturated = &ticks_ff;
   assign s_end     = saturated || (tick_ext >= EW'(sst_ff));
   assign g_end     = (grt_ff == '0) || saturated || (tick_ext >= EW'(grt_ff));
   // ramp points are only computed while the count is below a 16-bit length
   assign elapsed   = tick_ext[LEN_W-1:0];

   assign op_from = sel_g_ff ? gstart_ff : origin_ff;
   assign op_to   = sel_g_ff ? grun_ff   : target_ff;
   assign op_len  = sel_g_ff ? grt_ff    : sst_ff;
   assign op_lo   = sel_g_ff ? gfloor_ff : dfloor_ff;
   assign op_hi   = sel_g_ff ? gceil_ff  : dceil_ff;

   // |to - from| * elapsed, sign kept apart so the divide truncates toward zero
   assign mag     = (op_to >= op_from) ? (op_to - op_from) : (op_from - op_to);
   assign product = PROD_W'(mag) * PROD_W'(elapsed);

   // one restoring step per cycle
   assign rem_sh  = {rem_ff, quo_ff[DUTY_W-1]};
   assign qbit    = (rem_sh >= {1'b0, op_len});

   // the ramp point lies between from and to, so 10 bits never wrap
   assign ramp_raw = neg_ff ? (op_from - quo_ff) : (op_from + quo_ff);
   // ramp points take the floor first and the ceiling last, so crossed limits give the ceiling
   assign ramp_flr = (ramp_raw < op_lo) ? op_lo : ramp_raw;
   assign ramp_val = (ramp_flr > op_hi) ? op_hi : ramp_flr;

   always_comb begin
      state_in     = state_ff;
      active_in    = active_ff;
      ramp_s_in    = ramp_s_ff;
      ramp_g_in    = ramp_g_ff;
      ticks_in     = ticks_ff;
      origin_in    = origin_ff;
      target_in    = target_ff;
      present_in   = present_ff;
      grun_in      = grun_ff;
      drv_s_in     = drv_s_ff;
      drv_g_in     = drv_g_ff;
      sel_g_in     = sel_g_ff;
      need_g_in    = need_g_ff;
      neg_in       = neg_ff;
      rem_in       = rem_ff;
      quo_in       = quo_ff;
      cnt_in       = cnt_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_tready;
      rsp_data_in  = rsp_data_ff;

      case (state_ff)
         S_IDLE: begin
            if (req_xfer) begin
               state_in = S_EMIT;
               case (req_op)
                  OP_TICK: begin
                     if (active_ff) begin
                        if (!saturated) begin
                           ticks_in = ticks_ff + TICK_BITS'(1);
                        end
                        state_in = S_EVAL;
                     end
                  end
                  OP_START: begin
                     if (!active_ff) begin
                        grun_in   = clamp_duty(VALUE_W'(gdef_ff), gfloor_ff, gceil_ff);
                        active_in = 1'b1;
                        origin_in = present_ff;
                        ramp_s_in = (present_ff != target_ff);
                        ticks_in  = '0;
                        ramp_g_in = (grt_ff != '0);
                        drv_s_in  = present_ff;
                        drv_g_in  = (grt_ff != '0) ? gstart_ff : grun_in;
                     end
                  end
                  OP_STOP: begin
                     active_in  = 1'b0;
                     ramp_s_in  = 1'b0;
                     origin_in  = '0;
                     ramp_g_in  = 1'b0;
                     present_in = '0;
                     drv_s_in   = '0;
                     drv_g_in   = '0;
                  end
                  OP_TARGET: begin
                     target_in = (req_tdata > VALUE_W'(dceil_ff)) ?
                                 dceil_ff : req_tdata[DUTY_W-1:0];
                  end
                  OP_GATE: begin
                     grun_in = clamp_duty(req_tdata, gfloor_ff, gceil_ff);
                     if (active_ff && !ramp_g_ff) begin
                        drv_g_in = grun_in;
                     end
                  end
                  default: begin
                  end
               endcase
            end
         end

         S_EVAL: begin
            // supply side: end of ramp copies the target, otherwise a point is due
            if (!ramp_s_ff || s_end) begin
               ramp_s_in  = 1'b0;
               present_in = target_ff;
               drv_s_in   = target_ff;
            end
            // gate side
            need_g_in = 1'b0;
            if (ramp_g_ff) begin
               if (g_end) begin
                  ramp_g_in = 1'b0;
                  drv_g_in  = grun_ff;
               end else begin
                  need_g_in = 1'b1;
               end
            end else if (!ramp_s_ff) begin
               drv_g_in = grun_ff;
            end
            if (ramp_s_ff && !s_end) begin
               sel_g_in = 1'b0;
               state_in = S_MUL;
            end else if (ramp_g_ff && !g_end) begin
               sel_g_in = 1'b1;
               state_in = S_MUL;
            end else begin
               state_in = S_EMIT;
            end
         end

         S_MUL: begin
            neg_in   = (op_to < op_from);
            rem_in   = product[PROD_W-1:DUTY_W];
            quo_in   = product[DUTY_W-1:0];
            cnt_in   = '0;
            state_in = S_DIV;
         end

         S_DIV: begin
            rem_in = qbit ? LEN_W'(rem_sh - {1'b0, op_len}) : rem_sh[LEN_W-1:0];
            quo_in = {quo_ff[DUTY_W-2:0], qbit};
            cnt_in = cnt_ff + CNT_W'(1);
            if (cnt_ff == CNT_W'(DIV_STEPS - 1)) begin
               state_in = S_FIN;
            end
         end

         S_FIN: begin
            if (sel_g_ff) begin
               drv_g_in = ramp_val;
               state_in = S_EMIT;
            end else begin
               present_in = ramp_val;
               drv_s_in   = ramp_val;
               if (need_g_ff) begin
                  sel_g_in = 1'b1;
                  state_in = S_MUL;
               end else begin
                  state_in = S_EMIT;
               end
            end
         end

         S_EMIT: begin
            if (rsp_free) begin
               rsp_valid_in = 1'b1;
               rsp_data_in  = {1'b0, ramp_g_ff, ramp_s_ff, active_ff, drv_g_ff, drv_s_ff};
               state_in     = S_IDLE;
            end
         end

         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         rsp_valid_ff <= 1'b0;
         active_ff    <= 1'b0;
         ramp_s_ff    <= 1'b0;
         ramp_g_ff    <= 1'b0;
         ticks_ff     <= '0;
         origin_ff    <= '0;
         target_ff    <= '0;
         present_ff   <= '0;
         grun_ff      <= clamp_duty(VALUE_W'(RST_GATE_DEFAULT), RST_GATE_FLOOR,
                                    RST_GATE_CEILING);
         drv_s_ff     <= '0;
         drv_g_ff     <= '0;
         sel_g_ff     <= 1'b0;
         need_g_ff    <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
         active_ff    <= active_in;
         ramp_s_ff    <= ramp_s_in;
         ramp_g_ff    <= ramp_g_in;
         ticks_ff     <= ticks_in;
         origin_ff    <= origin_in;
         target_ff    <= target_in;
         present_ff   <= present_in;
         grun_ff      <= grun_in;
         drv_s_ff     <= drv_s_in;
         drv_g_ff     <= drv_g_in;
         sel_g_ff     <= sel_g_in;
         need_g_ff    <= need_g_in;
      end
   end

   // divider datapath and result payload
   always_ff @(posedge clock) begin
      neg_ff      <= neg_in;
      rem_ff      <= rem_in;
      quo_ff      <= quo_in;
      cnt_ff      <= cnt_in;
      rsp_data_ff <= rsp_data_in;
   end

   // register file
   always_ff @(posedge clock) begin
      if (reset) begin
         sst_ff    <= RST_SOFT_START_TICKS;
         grt_ff    <= RST_GATE_RAMP_TICKS;
         dfloor_ff <= RST_DUTY_FLOOR;
         dceil_ff  <= RST_DUTY_CEILING;
         gstart_ff <= RST_GATE_START_DUTY;
         gfloor_ff <= RST_GATE_FLOOR;
         gceil_ff  <= RST_GATE_CEILING;
         gdef_ff   <= RST_GATE_DEFAULT;
      end else if (csr_valid && csr_ready) begin
         case (reg_idx_type'(csr_index))
            REG_SOFT_START_TICKS: sst_ff    <= csr_data;
            REG_GATE_RAMP_TICKS:  grt_ff    <= csr_data;
            REG_DUTY_FLOOR:       dfloor_ff <= csr_data[DUTY_W-1:0];
            REG_DUTY_CEILING:     dceil_ff  <= csr_data[DUTY_W-1:0];
            REG_GATE_START_DUTY:  gstart_ff <= csr_data[DUTY_W-1:0];
            REG_GATE_FLOOR:       gfloor_ff <= csr_data[DUTY_W-1:0];
            REG_GATE_CEILING:     gceil_ff  <= csr_data[DUTY_W-1:0];
            REG_GATE_DEFAULT:     gdef_ff   <= csr_data[DUTY_W-1:0];
            default: begin
            end
         endcase
      end
   end

   // a command transfer always takes the block out of the idle state on the following clock
   `CHK_NEXT(a_busy_after_req, clock, reset, req_tvalid && req_tready, !req_tready)

   // ramps only run inside an active run
   `CHK_IMPLY(a_ramp_needs_active, clock, reset, !active_ff, !ramp_s_ff && !ramp_g_ff)

   // partial remainder stays below the ramp length through the divide
   `CHK_IMPLY(a_rem_below_len, clock, reset, state_ff == S_DIV, rem_ff < op_len)

endmodule
